// File: hdl/afi_pkg.sv
`default_nettype none

package afi_pkg;

  // filter order and table sizes
  localparam int FILTER_ORDER = 10;
  localparam int NUM_COEF     = FILTER_ORDER + 1;
  localparam int TERM_W       = $clog2(NUM_COEF);
  localparam int HIST_IDX_W   = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;

  // field widths
  localparam int IDX_W  = 4;
  localparam int COEF_W = 40;   // Q8.32
  localparam int SAMP_W = 24;   // Q1.23
  localparam int OPND_W = 32;   // Q8.24
  localparam int OUT_W  = 32;   // Q8.24

  // digit-serial multiplier: operand consumed one digit per cycle, MSB first
  localparam int DIGIT_W    = 8;
  localparam int NUM_DIGITS = OPND_W / DIGIT_W;
  localparam int DCNT_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int PPROD_W    = COEF_W + DIGIT_W + 1;
  localparam int PROD_W     = COEF_W + OPND_W;            // Q16.56
  localparam int ACC_W      = PROD_W + $clog2(NUM_COEF);

  // rounding to Q8.24: drop 32 fraction bits
  localparam int RND_SHIFT = 32;
  localparam int RES_W     = ACC_W - RND_SHIFT;

  // stream packing
  localparam int IN_TDATA_W  = ((IDX_W + COEF_W + SAMP_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // operation codes carried on tuser
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  // controls from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;   // zero the accumulator
    logic load;    // take a new coefficient and operand, zero the partial product
    logic step;    // consume one operand digit
    logic accum;   // add the finished product into the accumulator
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: hdl/afi_mac.sv
`default_nettype none

module afi_mac (
  input  wire                                    clk,
  input  wire afi_pkg::mac_ctl_t                 ctl,
  input  wire logic signed [afi_pkg::COEF_W-1:0] coef,
  input  wire logic        [afi_pkg::OPND_W-1:0] operand,
  output logic signed      [afi_pkg::ACC_W-1:0]  acc
);

  logic signed [afi_pkg::COEF_W-1:0]  coef_q;
  logic        [afi_pkg::OPND_W-1:0]  opnd_q;
  logic                               top_q;
  logic signed [afi_pkg::PROD_W-1:0]  prod;
  logic signed [afi_pkg::DIGIT_W:0]   digit;
  logic signed [afi_pkg::PPROD_W-1:0] pprod;
  logic signed [afi_pkg::PROD_W-1:0]  prod_next;

  // top digit is signed, lower digits are unsigned
  assign digit = top_q ? {opnd_q[afi_pkg::OPND_W-1], opnd_q[afi_pkg::OPND_W-1 -: afi_pkg::DIGIT_W]}
                       : {1'b0, opnd_q[afi_pkg::OPND_W-1 -: afi_pkg::DIGIT_W]};

  // one narrow partial product per cycle
  assign pprod = coef_q * digit;

  // Horner step: shift the running product up one digit and add
  assign prod_next = (prod <<< afi_pkg::DIGIT_W) + afi_pkg::PROD_W'(pprod);

  // operand shift register and partial product
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      coef_q <= coef;
      opnd_q <= operand;
      top_q  <= 1'b1;
      prod   <= '0;
    end else if (ctl.step) begin
      opnd_q <= opnd_q << afi_pkg::DIGIT_W;
      top_q  <= 1'b0;
      prod   <= prod_next;
    end
  end

  // accumulator over all terms
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.accum) begin
      acc <= acc + afi_pkg::ACC_W'(prod);
    end
  end

endmodule

`default_nettype wire

// File: hdl/afi_sat.sv
`default_nettype none

module afi_sat (
  input  wire logic signed [afi_pkg::ACC_W-1:0] acc,
  output logic             [afi_pkg::OUT_W-1:0] sample_out,
  output logic                                  clipped
);

  logic signed [afi_pkg::ACC_W-1:0] rsum;
  logic signed [afi_pkg::RES_W-1:0] res;
  logic                             sgn;

  // add one half LSB of Q8.24, then floor
  assign rsum = acc + (afi_pkg::ACC_W'(1) << (afi_pkg::RND_SHIFT - 1));
  assign res  = rsum[afi_pkg::ACC_W-1:afi_pkg::RND_SHIFT];
  assign sgn  = res[afi_pkg::RES_W-1];

  // in range when all bits above the output sign match it
  always_comb begin
    if (res[afi_pkg::RES_W-1:afi_pkg::OUT_W-1] == {(afi_pkg::RES_W - afi_pkg::OUT_W + 1){sgn}})
    begin
      sample_out = res[afi_pkg::OUT_W-1:0];
      clipped    = 1'b0;
    end else begin
      sample_out = {sgn, {(afi_pkg::OUT_W - 1){~sgn}}};
      clipped    = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hdl/all_pole_formant_iir_filter_top.sv
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_*       in   tdata: coef_index[3:0], coef_value[43:4], sample_in[67:44], zero pad
//                tuser: operation (0 filter sample, 1 write coefficient)
// m_*       out  tdata: sample_out[31:0]; tuser: clipped
//
// A filter transfer is accepted in the idle state: then each of the eleven terms loads,
// runs NUM_DIGITS digit steps through the one shared 40x9 multiplier and adds into the
// accumulator, then the final state hands the result to m_*; s_tready stays low throughout.
// A coefficient write is taken in the idle state and leaves the sequencer there.
// rst clears the coefficient table and the history.
// Input is taken again while a finished result waits on m_*; a second result
// holds in the final state until the output register is free.
`default_nettype none

module all_pole_formant_iir_filter_top (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire  [afi_pkg::IN_TDATA_W-1:0]       s_tdata,   // coef_index, coef_value, sample_in
  input  wire                                  s_tuser,   // operation
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [afi_pkg::OUT_TDATA_W-1:0]      m_tdata,   // sample_out
  output logic                                 m_tuser    // clipped
);

  localparam int CV_LO = afi_pkg::IDX_W;
  localparam int SI_LO = afi_pkg::IDX_W + afi_pkg::COEF_W;
  localparam int XPAD  = afi_pkg::OPND_W - afi_pkg::SAMP_W - 1;

  afi_pkg::state_t   state, state_next;
  afi_pkg::mac_ctl_t ctl;

  logic [afi_pkg::TERM_W-1:0] term;
  logic [afi_pkg::DCNT_W-1:0] dcnt;
  logic [afi_pkg::OPND_W-1:0] x_q;

  logic signed [afi_pkg::COEF_W-1:0] coef_tab [afi_pkg::NUM_COEF];
  logic        [afi_pkg::OUT_W-1:0]  hist     [afi_pkg::FILTER_ORDER];

  logic [afi_pkg::IDX_W-1:0]         in_idx;
  logic signed [afi_pkg::COEF_W-1:0] in_coef;
  logic [afi_pkg::SAMP_W-1:0]        in_samp;
  logic                              in_xfer;
  logic                              out_free;
  logic                              deliver;

  logic [afi_pkg::OPND_W-1:0]        operand;
  logic signed [afi_pkg::ACC_W-1:0]  acc;
  logic [afi_pkg::OUT_W-1:0]         sat_out;
  logic                              sat_clip;

  assign in_idx   = s_tdata[afi_pkg::IDX_W-1:0];
  assign in_coef  = s_tdata[SI_LO-1:CV_LO];
  assign in_samp  = s_tdata[SI_LO + afi_pkg::SAMP_W - 1:SI_LO];
  assign s_tready = (state == afi_pkg::ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign deliver  = (state == afi_pkg::ST_DONE) && out_free;

  // operand for the current term: the widened sample, then the history
  assign operand = (term == '0) ? x_q
                 : afi_pkg::OPND_W'(hist[afi_pkg::HIST_IDX_W'(term - 1'b1)]);

  afi_mac u_mac (
    .clk     (clk),
    .ctl     (ctl),
    .coef    (coef_tab[term]),
    .operand (operand),
    .acc     (acc)
  );

  afi_sat u_sat (
    .acc        (acc),
    .sample_out (sat_out),
    .clipped    (sat_clip)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= afi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit controls
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      afi_pkg::ST_IDLE: begin
        if (in_xfer && (s_tuser == afi_pkg::OP_FILTER)) begin
          ctl.clear  = 1'b1;
          state_next = afi_pkg::ST_LOAD;
        end
      end
      afi_pkg::ST_LOAD: begin
        ctl.load   = 1'b1;
        state_next = afi_pkg::ST_MUL;
      end
      afi_pkg::ST_MUL: begin
        ctl.step = 1'b1;
        if (dcnt == afi_pkg::DCNT_W'(afi_pkg::NUM_DIGITS - 1)) begin
          state_next = afi_pkg::ST_ACC;
        end
      end
      afi_pkg::ST_ACC: begin
        ctl.accum = 1'b1;
        if (term == afi_pkg::TERM_W'(afi_pkg::FILTER_ORDER)) begin
          state_next = afi_pkg::ST_DONE;
        end else begin
          state_next = afi_pkg::ST_LOAD;
        end
      end
      afi_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = afi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = afi_pkg::ST_IDLE;
      end
    endcase
  end

  // term and digit counters
  always_ff @(posedge clk) begin
    if (rst) begin
      term <= '0;
      dcnt <= '0;
    end else begin
      if (in_xfer) begin
        term <= '0;
      end else if ((state == afi_pkg::ST_ACC)
                   && (term != afi_pkg::TERM_W'(afi_pkg::FILTER_ORDER))) begin
        term <= term + 1'b1;
      end
      if (state == afi_pkg::ST_LOAD) begin
        dcnt <= '0;
      end else if (state == afi_pkg::ST_MUL) begin
        dcnt <= dcnt + 1'b1;
      end
    end
  end

  // Q1.23 -> Q8.24: sign extend and shift left by one
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_q <= {{XPAD{in_samp[afi_pkg::SAMP_W-1]}}, in_samp, 1'b0};
    end
  end

  // coefficient table; writes beyond the order are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < afi_pkg::NUM_COEF; i++) begin
        coef_tab[i] <= '0;
      end
    end else if (in_xfer && (s_tuser == afi_pkg::OP_WRITE)
                 && (int'(in_idx) <= afi_pkg::FILTER_ORDER)) begin
      coef_tab[afi_pkg::TERM_W'(in_idx)] <= in_coef;
    end
  end

  // output history: saturated result shifts in at delivery
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < afi_pkg::FILTER_ORDER; i++) begin
        hist[i] <= '0;
      end
    end else if (deliver) begin
      for (int i = afi_pkg::FILTER_ORDER - 1; i > 0; i--) begin
        hist[i] <= hist[i - 1];
      end
      hist[0] <= sat_out;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (deliver) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      m_tdata <= afi_pkg::OUT_TDATA_W'(sat_out);
      m_tuser <= sat_clip;
    end
  end

endmodule

`default_nettype wire
